// ===== rtl/tpm_pkg.sv =====
// Shared types and constants for the tree path midpoint query block.
package tpm_pkg;

  localparam int NodeW  = 16;
  localparam int IdW    = 15;
  localparam int DepthW = 15;
  localparam int SW     = 20;

  localparam logic [NodeW-1:0]  NO_NODE   = 16'h8000;
  localparam logic [DepthW-1:0] DEPTH_MAX = 15'h7fff;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic           single_meet;
    logic [IdW-1:0] first_node;
    logic [IdW-1:0] second_node;
  } res_t;

endpackage

// ===== rtl/tpm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tpm_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tpm_core.sv =====
// Sequencer for node loads, ancestor table build and midpoint queries over three RAMs.
module tpm_core import tpm_pkg::*; #(
  parameter int MAX_NODES   = 32768,
  parameter int JUMP_LEVELS = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [IdW-1:0]   node_a_i,
  input  logic [IdW-1:0]   node_b_i,
  input  logic             is_root_i,
  input  logic [15:0]      node_count_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int LW  = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
  localparam int LLW = LW + 1;
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int TW  = AW + LW;
  localparam logic signed [SW-1:0] SOne = 1;

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_LD_RD  = 23'h000002,
    S_LD_WR  = 23'h000004,
    S_B_RD   = 23'h000008,
    S_B_MID  = 23'h000010,
    S_B_WR   = 23'h000020,
    S_Q_RDA  = 23'h000040,
    S_Q_RDB  = 23'h000080,
    S_Q_SW   = 23'h000100,
    S_C_TEST = 23'h000200,
    S_C_ANC  = 23'h000400,
    S_C_DEP  = 23'h000800,
    S_C_DONE = 23'h001000,
    S_L_RD1  = 23'h002000,
    S_L_RD2  = 23'h004000,
    S_L_CMP  = 23'h008000,
    S_P_RD   = 23'h010000,
    S_P_GET  = 23'h020000,
    S_U_RD   = 23'h040000,
    S_U_GET  = 23'h080000,
    S_PN_SET = 23'h100000,
    S_PN_GO  = 23'h200000,
    S_OUT    = 23'h400000
  } state_e;

  typedef enum logic [1:0] {
    PH_CA  = 2'd0,
    PH_PN1 = 2'd1,
    PH_PN2 = 2'd2
  } phase_e;

  function automatic logic node_missing(input logic [NodeW-1:0] v);
    node_missing = (32'(v) >= 32'(MAX_NODES)) || (v == NO_NODE);
  endfunction

  function automatic logic anc_ok(input logic [NodeW-1:0] v, input logic [LW-1:0] lvl,
                                  input logic [CW-1:0] bn, input logic [LLW-1:0] ll);
    anc_ok = !node_missing(v) && (32'(v) < 32'(bn)) && (LLW'(lvl) < ll);
  endfunction

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [CW-1:0]  built_n_q, built_n_d;
  logic [LLW-1:0] lev_lim_q, lev_lim_d;

  logic                    root_q, root_d;
  logic [NodeW-1:0]        a_q, a_d, b_q, b_d, p_q, p_d, q_q, q_d;
  logic [NodeW-1:0]        u_q, u_d, ap_q, ap_d, x_q, x_d;
  logic [DepthW-1:0]       da_q, da_d, db_q, db_d, dp_q, dp_d, du_q, du_d;
  logic signed [SW-1:0]    y_q, y_d, k_q, k_d, d_q, d_d;
  logic [LW-1:0]           i_q, i_d, j_q, j_d;
  logic [CW-1:0]           row_q, row_d;
  logic [IdW-1:0]          r1_q, r1_d;
  res_t                    res_q, res_d;

  logic              par_we, dep_we, anc_we;
  logic [AW-1:0]     par_waddr, par_raddr, dep_waddr, dep_raddr;
  logic [TW-1:0]     anc_waddr, anc_raddr;
  logic [NodeW-1:0]  par_wdata, par_rdata, anc_wdata, anc_rdata;
  logic [DepthW-1:0] dep_wdata, dep_rdata;

  logic [CW-1:0]        n_eff;
  logic [LW-1:0]        top_lvl;
  logic signed [SW-1:0] pow, lhs;
  logic                 take;

  always_comb begin
    logic [31:0] nc;
    nc = 32'(node_count_i);
    if (nc == 32'd0) begin
      n_eff = CW'(1);
    end else if (nc > 32'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(nc);
    end
  end

  always_comb begin
    int t;
    t = 0;
    for (int bi = 1; bi < CW; bi++) begin
      if (n_eff[bi]) begin
        t = bi;
      end
    end
    if (t > JUMP_LEVELS - 1) begin
      t = JUMP_LEVELS - 1;
    end
    top_lvl = LW'(t);
  end

  assign pow  = SOne <<< i_q;
  assign lhs  = $signed(SW'(dp_q)) - pow;
  assign take = lhs >= y_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_comb begin
    logic [NodeW-1:0]     pn, aq;
    logic [DepthW-1:0]    dw;
    logic signed [SW-1:0] ds;
    logic [LLW-1:0]       jn;
    logic                 adv;
    logic [IdW-1:0]       r2;

    state_d   = state_q;
    phase_d   = phase_q;
    built_n_d = built_n_q;
    lev_lim_d = lev_lim_q;
    root_d    = root_q;
    a_d  = a_q;  b_d  = b_q;  p_d  = p_q;  q_d  = q_q;
    u_d  = u_q;  ap_d = ap_q; x_d  = x_q;
    da_d = da_q; db_d = db_q; dp_d = dp_q; du_d = du_q;
    y_d  = y_q;  k_d  = k_q;  d_d  = d_q;
    i_d  = i_q;  j_d  = j_q;  row_d = row_q;
    r1_d = r1_q; res_d = res_q;

    par_we = 1'b0; par_waddr = a_q[AW-1:0]; par_wdata = NO_NODE; par_raddr = p_q[AW-1:0];
    dep_we = 1'b0; dep_waddr = a_q[AW-1:0]; dep_wdata = '0;      dep_raddr = a_q[AW-1:0];
    anc_we = 1'b0; anc_waddr = {row_q[AW-1:0], j_q}; anc_wdata = NO_NODE;
    anc_raddr = {p_q[AW-1:0], i_q};

    pn  = NO_NODE;
    aq  = NO_NODE;
    dw  = '0;
    ds  = '0;
    jn  = '0;
    adv = 1'b0;
    r2  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d    = {1'b0, node_a_i};
          b_d    = {1'b0, node_b_i};
          root_d = is_root_i;
          case (kind_e'(kind_i))
            KIND_LOAD: begin
              if (32'(node_a_i) < 32'(MAX_NODES)) begin
                state_d = S_LD_RD;
              end
            end
            KIND_BUILD: begin
              built_n_d = n_eff;
              lev_lim_d = '0;
              j_d       = '0;
              row_d     = '0;
              state_d   = S_B_RD;
            end
            KIND_QUERY: state_d = S_Q_RDA;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LD_RD: begin
        dep_raddr = b_q[AW-1:0];
        state_d   = S_LD_WR;
      end
      S_LD_WR: begin
        par_we = 1'b1;
        dep_we = 1'b1;
        if (root_q || node_missing(b_q)) begin
          par_wdata = NO_NODE;
          dep_wdata = '0;
        end else begin
          par_wdata = b_q;
          dep_wdata = (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + 1'b1;
        end
        state_d = S_IDLE;
      end
      S_B_RD: begin
        par_raddr = row_q[AW-1:0];
        anc_raddr = {row_q[AW-1:0], LW'(j_q - 1'b1)};
        state_d   = S_B_MID;
      end
      S_B_MID: begin
        if (j_q == '0) begin
          anc_we    = 1'b1;
          anc_wdata = par_rdata;
          adv       = 1'b1;
        end else begin
          x_d       = anc_rdata;
          anc_raddr = {anc_rdata[AW-1:0], LW'(j_q - 1'b1)};
          state_d   = S_B_WR;
        end
      end
      S_B_WR: begin
        anc_we    = 1'b1;
        anc_wdata = anc_ok(x_q, LW'(j_q - 1'b1), built_n_q, lev_lim_q) ? anc_rdata : NO_NODE;
        adv       = 1'b1;
      end
      S_Q_RDA: begin
        dep_raddr = a_q[AW-1:0];
        state_d   = S_Q_RDB;
      end
      S_Q_RDB: begin
        da_d      = node_missing(a_q) ? '0 : dep_rdata;
        dep_raddr = b_q[AW-1:0];
        state_d   = S_Q_SW;
      end
      S_Q_SW: begin
        dw   = node_missing(b_q) ? '0 : dep_rdata;
        db_d = dw;
        if (da_q < dw) begin
          p_d  = b_q;
          q_d  = a_q;
          dp_d = dw;
          y_d  = $signed(SW'(da_q));
        end else begin
          p_d  = a_q;
          q_d  = b_q;
          dp_d = da_q;
          y_d  = $signed(SW'(dw));
        end
        i_d     = top_lvl;
        phase_d = PH_CA;
        state_d = S_C_TEST;
      end
      S_C_TEST: begin
        anc_raddr = {p_q[AW-1:0], i_q};
        if (take) begin
          state_d = S_C_ANC;
        end else if (i_q == '0) begin
          state_d = S_C_DONE;
        end else begin
          i_d = i_q - 1'b1;
        end
      end
      S_C_ANC: begin
        pn        = anc_ok(p_q, i_q, built_n_q, lev_lim_q) ? anc_rdata : NO_NODE;
        p_d       = pn;
        dep_raddr = pn[AW-1:0];
        state_d   = S_C_DEP;
      end
      S_C_DEP: begin
        dp_d = node_missing(p_q) ? '0 : dep_rdata;
        if (i_q == '0) begin
          state_d = S_C_DONE;
        end else begin
          i_d     = i_q - 1'b1;
          state_d = S_C_TEST;
        end
      end
      S_C_DONE: begin
        case (phase_q)
          PH_CA: begin
            if (p_q == q_q) begin
              u_d     = p_q;
              state_d = S_U_RD;
            end else begin
              i_d     = top_lvl;
              state_d = S_L_RD1;
            end
          end
          PH_PN1: begin
            r1_d = p_q[IdW-1:0];
            if (d_q[0] == 1'b0) begin
              res_d.single_meet = 1'b1;
              res_d.first_node  = p_q[IdW-1:0];
              res_d.second_node = p_q[IdW-1:0];
              state_d = S_OUT;
            end else begin
              k_d     = k_q + SOne;
              phase_d = PH_PN2;
              state_d = S_PN_GO;
            end
          end
          default: begin
            r2 = p_q[IdW-1:0];
            res_d.single_meet = 1'b0;
            res_d.first_node  = (r1_q > r2) ? r2 : r1_q;
            res_d.second_node = (r1_q > r2) ? r1_q : r2;
            state_d = S_OUT;
          end
        endcase
      end
      S_L_RD1: begin
        anc_raddr = {p_q[AW-1:0], i_q};
        state_d   = S_L_RD2;
      end
      S_L_RD2: begin
        ap_d      = anc_ok(p_q, i_q, built_n_q, lev_lim_q) ? anc_rdata : NO_NODE;
        anc_raddr = {q_q[AW-1:0], i_q};
        state_d   = S_L_CMP;
      end
      S_L_CMP: begin
        aq = anc_ok(q_q, i_q, built_n_q, lev_lim_q) ? anc_rdata : NO_NODE;
        if ((ap_q != NO_NODE) && (ap_q != aq)) begin
          p_d = ap_q;
          q_d = aq;
        end
        if (i_q == '0) begin
          state_d = S_P_RD;
        end else begin
          i_d     = i_q - 1'b1;
          state_d = S_L_RD1;
        end
      end
      S_P_RD: begin
        par_raddr = p_q[AW-1:0];
        state_d   = S_P_GET;
      end
      S_P_GET: begin
        u_d     = node_missing(p_q) ? NO_NODE : par_rdata;
        state_d = S_U_RD;
      end
      S_U_RD: begin
        dep_raddr = u_q[AW-1:0];
        state_d   = S_U_GET;
      end
      S_U_GET: begin
        dw   = node_missing(u_q) ? '0 : dep_rdata;
        du_d = dw;
        ds   = $signed(SW'(da_q)) + $signed(SW'(db_q)) - $signed(SW'({dw, 1'b0}));
        d_d  = (ds < 0) ? '0 : ds;
        state_d = S_PN_SET;
      end
      S_PN_SET: begin
        k_d     = (d_q[0] == 1'b0) ? (d_q >>> 1) + SOne : (d_q + SOne) >>> 1;
        phase_d = PH_PN1;
        state_d = S_PN_GO;
      end
      S_PN_GO: begin
        if ($signed(SW'(da_q)) - $signed(SW'(du_q)) + SOne >= k_q) begin
          p_d  = a_q;
          dp_d = da_q;
          y_d  = $signed(SW'(da_q)) - k_q + SOne;
        end else begin
          p_d  = b_q;
          dp_d = db_q;
          y_d  = k_q - $signed(SW'(da_q)) + $signed(SW'({du_q, 1'b0})) - SOne;
        end
        i_d     = top_lvl;
        state_d = S_C_TEST;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (adv) begin
      if (CW'(row_q + 1'b1) == built_n_q) begin
        lev_lim_d = lev_lim_q + 1'b1;
        jn        = LLW'(j_q) + 1'b1;
        row_d     = '0;
        if ((32'(jn) < 32'(JUMP_LEVELS)) && ((32'd1 << jn) < 32'(built_n_q))) begin
          j_d     = jn[LW-1:0];
          state_d = S_B_RD;
        end else begin
          state_d = S_IDLE;
        end
      end else begin
        row_d   = CW'(row_q + 1'b1);
        state_d = S_B_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_CA;
      built_n_q <= '0;
      lev_lim_q <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      built_n_q <= built_n_d;
      lev_lim_q <= lev_lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    a_q  <= a_d;  b_q  <= b_d;  p_q  <= p_d;  q_q  <= q_d;
    u_q  <= u_d;  ap_q <= ap_d; x_q  <= x_d;
    da_q <= da_d; db_q <= db_d; dp_q <= dp_d; du_q <= du_d;
    y_q  <= y_d;  k_q  <= k_d;  d_q  <= d_d;
    i_q  <= i_d;  j_q  <= j_d;  row_q <= row_d;
    r1_q <= r1_d; res_q <= res_d;
  end

  tpm_ram #(.W(NodeW), .D(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  tpm_ram #(.W(DepthW), .D(MAX_NODES)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  tpm_ram #(.W(NodeW), .D(MAX_NODES << LW)) u_anc_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .raddr_i (anc_raddr),
    .rdata_o (anc_rdata)
  );

endmodule

// ===== rtl/tree_path_midpoint_query_top.sv =====
// Top level: APB register, query sequencer and output register.
// Load reads the parent's depth, then writes parent and depth. Build: B_RD, B_MID per node for
// level 0, plus B_WR per node for each higher level. Query: each climb step costs one
// ancestor read and one depth read on the single read port of each RAM.
// One item at a time; a finished result waits in the output register while the next beat enters.
// Reset clears control state and sets node_count to 1; the RAMs are not cleared.
module tree_path_midpoint_query_top import tpm_pkg::*; #(
  parameter int MAX_NODES   = 32768,
  parameter int JUMP_LEVELS = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     kind_i,
  input  logic [IdW-1:0] node_a_i,
  input  logic [IdW-1:0] node_b_i,
  input  logic           is_root_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           single_meet_o,
  output logic [IdW-1:0] first_node_o,
  output logic [IdW-1:0] second_node_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam logic RegNodeCount = 1'b0;

  logic [15:0] node_count_q, node_count_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;
  logic        res_valid, res_ready;
  res_t        res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegNodeCount) ? {16'h0, node_count_q} : 32'h0;

  always_comb begin
    node_count_d = node_count_q;
    if (psel && penable && pwrite && (paddr[2] == RegNodeCount)) begin
      node_count_d = pwdata[15:0];
    end
  end

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 16'd1;
      out_valid_q  <= 1'b0;
    end else begin
      node_count_q <= node_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign single_meet_o = out_q.single_meet;
  assign first_node_o  = out_q.first_node;
  assign second_node_o = out_q.second_node;

  tpm_core #(.MAX_NODES(MAX_NODES), .JUMP_LEVELS(JUMP_LEVELS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .is_root_i    (is_root_i),
    .node_count_i (node_count_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

endmodule
